@@ sv/sfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg: shared constants for the stack fold calculator
// Operation and status codes, field widths.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef logic [DATA_W-1:0] word_t;

    // add, subtract, multiply and divide fold the whole stack
    function automatic logic is_fold(input logic [OP_W-1:0] op);
        return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

@@ sv/sfc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_if: request and result channels of the stack fold calculator
// Valid/ready handshake; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface sfc_req_if
    import sfc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

interface sfc_res_if
    import sfc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top_value;
    logic [CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output status, output top_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input entry_count,
                    output ready);
endinterface

@@ sv/sfc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_div: signed 32-bit divider, truncating toward zero
// Restoring radix-2, one quotient bit per cycle; done pulses once the
// last quotient bit is in. Caller guarantees a nonzero divisor.
// ----------------------------------------------------------------------------
module sfc_div
    import sfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t quo
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    word_t             q_reg, q_next;
    word_t             rem_reg, rem_next;
    word_t             dmag_reg, dmag_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, q_reg[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, dmag_reg};
    assign ge       = !rem_diff[DATA_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            q_next    = num[DATA_W-1] ? (word_t'(0) - num) : num;
            dmag_next = den[DATA_W-1] ? (word_t'(0) - den) : den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            q_next    = {q_reg[DATA_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (word_t'(0) - q_reg) : q_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider started while busy");
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider stopped without done");
`endif

endmodule

@@ sv/stack_fold_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_fold_calculator: reverse-polish calculator with stack folding
// Push, add, subtract, multiply, divide and finish requests on a stack of
// 32-bit signed values; one result per request.
// ----------------------------------------------------------------------------
// The stack lives in a single-port-per-direction synchronous RAM of
// STACK_DEPTH words (registered read). A push with room writes the RAM
// and goes straight to its result; a push onto a full stack, a finish or
// an unused code first reads the top. On an empty stack nothing but a push
// reads. An operator reads the top, then folds one lower entry per cycle
// for add, subtract and multiply, while divide runs each lower entry
// through the bit-serial divider, which sets the rate for division.
// The fold walk and the divider share the RAM read data
// register; reads and writes never touch the same cycle, so no
// forwarding is needed. A new request is taken as soon as the previous
// result sits in the output register, even if the sink has not taken it.
// entry_count reports the stack count modulo 128. RAM contents are not
// cleared at reset; entries above the count are never read.
// ----------------------------------------------------------------------------
module stack_fold_calculator
    import sfc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfc_req_if.sink   req,
    sfc_res_if.source res
);

    localparam int AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int CNT_X_W = CNT_W + CNT_OUT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_TOP  = 3'd1;  // top-of-stack read returning
    localparam logic [2:0] S_FOLD = 3'd2;  // lower entry read returning
    localparam logic [2:0] S_DIV  = 3'd3;  // divider running
    localparam logic [2:0] S_EMIT = 3'd4;  // result waiting for output register

    // stack RAM
    word_t          mem [STACK_DEPTH];
    word_t          rdata_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    word_t          wr_data;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    word_t               acc_reg, acc_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    word_t               pend_value_reg, pend_value_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    word_t               out_value_reg, out_value_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;

    logic                step_acc;
    word_t               acc_new;
    word_t               product;
    logic [CNT_W-1:0]    count_m1;
    logic [CNT_X_W-1:0]  count_ext;

    logic  div_start;
    logic  div_done;
    word_t div_quo;

    sfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rdata_reg),
        .den   (acc_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // only the low word of the product is kept, so it wraps at 32 bits
    assign product  = rdata_reg * acc_reg;
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        op_next          = op_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        out_count_next   = out_count_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        div_start        = 1'b0;
        step_acc         = 1'b0;
        acc_new          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.op;
                    priority if (req.op == OP_PUSH)
                    begin
                        if (count_reg < CNT_W'(STACK_DEPTH))
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = count_reg[AW-1:0];
                            wr_data          = req.operand;
                            count_next       = count_reg + CNT_W'(1);
                            pend_status_next = ST_OK;
                            pend_value_next  = req.operand;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = count_m1[AW-1:0];
                            state_next = S_TOP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing to read: empty error, or a plain zero for unused codes
                        pend_status_next = (is_fold(req.op) || req.op == OP_FINISH)
                                           ? ST_EMPTY : ST_OK;
                        pend_value_next  = '0;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = count_m1[AW-1:0];
                        idx_next   = count_m1[AW-1:0];
                        state_next = S_TOP;
                        if (req.op == OP_FINISH)
                        begin
                            count_next = count_m1;
                        end
                    end
                end
            end
            S_TOP:
            begin
                if (is_fold(op_reg))
                begin
                    step_acc = 1'b1;
                    acc_new  = rdata_reg;
                end
                else
                begin
                    pend_status_next = (op_reg == OP_PUSH) ? ST_FULL : ST_OK;
                    pend_value_next  = rdata_reg;
                    state_next       = S_EMIT;
                end
            end
            S_FOLD:
            begin
                priority if (op_reg == OP_DIV)
                begin
                    if (acc_reg == '0)
                    begin
                        count_next       = '0;
                        pend_status_next = ST_DIVZERO;
                        pend_value_next  = '0;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else if (op_reg == OP_ADD)
                begin
                    step_acc = 1'b1;
                    acc_new  = rdata_reg + acc_reg;
                end
                else if (op_reg == OP_SUB)
                begin
                    step_acc = 1'b1;
                    acc_new  = rdata_reg - acc_reg;
                end
                else
                begin
                    step_acc = 1'b1;
                    acc_new  = product;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    step_acc = 1'b1;
                    acc_new  = div_quo;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_value_next  = pend_value_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // fold step: either the walk reaches the bottom and writes back, or
        // the next lower entry is fetched
        if (step_acc)
        begin
            acc_next = acc_new;
            if (idx_reg == '0)
            begin
                wr_en            = 1'b1;
                wr_addr          = '0;
                wr_data          = acc_new;
                count_next       = CNT_W'(1);
                pend_status_next = ST_OK;
                pend_value_next  = acc_new;
                state_next       = S_EMIT;
            end
            else
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg - AW'(1);
                idx_next   = idx_reg - AW'(1);
                state_next = S_FOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        acc_reg         <= acc_next;
        op_reg          <= op_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        out_status_reg  <= out_status_next;
        out_value_reg   <= out_value_next;
        out_count_reg   <= out_count_next;
    end

    // stack RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign count_ext = CNT_X_W'(out_count_reg);

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.top_value   = out_value_reg;
    assign res.entry_count = count_ext[CNT_OUT_W-1:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");
    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("stack RAM read and write in the same cycle");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (acc_reg != '0))
        else $error("divider started with zero divisor");
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !$past(res.valid)) |-> $past(state_reg == S_EMIT))
        else $error("result appeared outside the emit step");
`endif

endmodule

@@ dv/stack_fold_calculator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_fold_calculator_test: self-checking bench for the stack fold calculator
// Drives push, fold, finish and unused-code requests through the
// valid/ready request channel with bursty timing and checks every result
// against an in-bench model of the stack, under random and long output stalls.
// ----------------------------------------------------------------------------
module stack_fold_calculator_test;
    import sfc_pkg::*;

    localparam int CALC_DEPTH     = 64;
    localparam int ITEM_TARGET    = 1150;
    localparam int LONG_HOLD      = 600;    // long result-side hold-off, in cycles
    localparam int HOLD_SPACING   = 550;    // results between long hold-offs
    localparam int WATCHDOG_LIMIT = 20000;  // longer than a full-depth divide
    localparam int TAIL_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;

    // one request waiting to be driven; drain holds it back until all
    // outstanding results have come back
    typedef struct {
        logic [OP_W-1:0] op;
        word_t           operand;
        bit              drain;
    } calc_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        word_t                top_value;
        logic [CNT_OUT_W-1:0] entry_count;
    } calc_result_t;

    typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, MOSTLY_READY} sink_mode_t;

    logic clk;
    logic rst_n;

    sfc_req_if req_ch ();
    sfc_res_if res_ch ();

    stack_fold_calculator #(
        .STACK_DEPTH(CALC_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Stack model: its own copy of the entries and the count
    // ------------------------------------------------------------------
    word_t calc_stack [CALC_DEPTH];
    int    calc_count;

    calc_request_t pending_reqs[$];
    calc_result_t  expected_results[$];

    int  stim_count;
    int  mismatch_count;
    int  results_seen;
    int  idle_cycles;
    bit  req_fire;

    function automatic word_t stack_top();
        return (calc_count == 0) ? '0 : calc_stack[calc_count - 1];
    endfunction

    // Applies one accepted request to the stack model and returns the result
    // the block must produce for it.
    function automatic calc_result_t apply_request(input logic [OP_W-1:0] op,
                                                   input word_t operand);
        calc_result_t r;
        word_t        acc;
        word_t        b;
        word_t        nmag;
        word_t        dmag;
        word_t        quo;
        int           i;
        r.status    = ST_OK;
        r.top_value = '0;
        if (op == OP_PUSH)
        begin
            if (calc_count >= CALC_DEPTH)
            begin
                // full: stack untouched, report current top
                r.status    = ST_FULL;
                r.top_value = stack_top();
            end
            else
            begin
                calc_stack[calc_count] = operand;
                calc_count++;
                r.top_value = operand;
            end
        end
        else if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV)
        begin
            if (calc_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                // right fold from the top: acc = b op acc for each lower entry
                acc = calc_stack[calc_count - 1];
                for (i = calc_count - 1; i > 0 && r.status == ST_OK; i--)
                begin
                    b = calc_stack[i - 1];
                    case (op)
                        OP_ADD: acc = b + acc;
                        OP_SUB: acc = b - acc;
                        OP_MUL: acc = b * acc;
                        default:
                        begin
                            if (acc == '0)
                            begin
                                r.status = ST_DIVZERO;
                            end
                            else
                            begin
                                // truncate toward zero on magnitudes; the most
                                // negative value over minus one wraps to itself
                                nmag = b[DATA_W-1] ? -b : b;
                                dmag = acc[DATA_W-1] ? -acc : acc;
                                quo  = nmag / dmag;
                                acc  = (b[DATA_W-1] ^ acc[DATA_W-1]) ? -quo : quo;
                            end
                        end
                    endcase
                end
                if (r.status == ST_DIVZERO)
                begin
                    calc_count = 0;
                end
                else
                begin
                    calc_stack[0] = acc;
                    calc_count    = 1;
                    r.top_value   = acc;
                end
            end
        end
        else if (op == OP_FINISH)
        begin
            if (calc_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.top_value = calc_stack[calc_count - 1];
                calc_count--;
            end
        end
        else
        begin
            // unused codes leave the stack alone
            r.top_value = stack_top();
        end
        r.entry_count = CNT_OUT_W'(calc_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [OP_W-1:0] op, input word_t operand,
                                 input bit drain);
        calc_request_t item;
        item.op      = op;
        item.operand = operand;
        item.drain   = drain;
        pending_reqs.push_back(item);
        if (op <= OP_FINISH)
            stim_count++;
    endtask

    // Operand mix: extremes, small values (so divisions keep nonzero
    // quotients and zero divisors show up) and full-range words.
    function automatic word_t pick_value();
        word_t v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(DATA_W-1){1'b0}}};
                    1:       v = {1'b0, {(DATA_W-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = word_t'(1);
                endcase
            end
            1, 2, 3: v = word_t'($urandom_range(0, 200)) - word_t'(100);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them.
    // Changes inputs on the falling edge; req_fire says whether the item on
    // the bus was taken at the last rising edge.
    // ------------------------------------------------------------------
    int drv_burst_left;
    int drv_gap_left;

    always @(negedge clk)
    begin
        if (rst_n && !(req_ch.valid && !req_fire))
        begin
            if (drv_gap_left > 0)
            begin
                drv_gap_left <= drv_gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_results.size() != 0))
            begin
                req_ch.valid   <= 1'b1;
                req_ch.op      <= pending_reqs[0].op;
                req_ch.operand <= pending_reqs[0].operand;
                void'(pending_reqs.pop_front());
                if (drv_burst_left <= 1)
                begin
                    drv_burst_left <= $urandom_range(1, 24);
                    // a quarter of the bursts run straight into the next one
                    drv_gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    drv_burst_left <= drv_burst_left - 1;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: the stall pattern switches to a random mode when the current mode's random run ends.
    // Every HOLD_SPACING results it holds ready low for a LONG_HOLD hold-off so the
    // block backs up and drops req.ready while the driver keeps offering.
    // ------------------------------------------------------------------
    sink_mode_t sink_mode;
    int         mode_left;
    int         hold_left;
    int         next_hold_at;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (results_seen >= next_hold_at)
        begin
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + HOLD_SPACING;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                sink_mode <= sink_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(50, 300);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (sink_mode)
                ALWAYS_READY:   res_ch.ready <= 1'b1;
                COIN_FLIP:      res_ch.ready <= 1'($urandom_range(0, 1));
                MOSTLY_STALLED: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:        res_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker, on the rising edge. The result is checked before
    // the request of the same edge is predicted: a result can never belong
    // to a request taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        calc_result_t want;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%t: unexpected result status %0d top %0d count %0d",
                                 $realtime, res_ch.status, $signed(res_ch.top_value),
                                 res_ch.entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.status !== want.status ||
                        res_ch.top_value !== want.top_value ||
                        res_ch.entry_count !== want.entry_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%t: result %0d mismatch: expected status %0d top %0d",
                                      " count %0d, got status %0d top %0d count %0d"},
                                     $realtime, results_seen, want.status,
                                     $signed(want.top_value), want.entry_count,
                                     res_ch.status, $signed(res_ch.top_value),
                                     res_ch.entry_count);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(apply_request(req_ch.op, req_ch.operand));
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles in which neither channel moves anything
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stack_fold_calculator test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int  n;
        int  j;
        int  kind;
        int  fills;
        bit  drain;
        bit  first_seq;
        logic [OP_W-1:0] fold_op;

        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_PUSH;
        req_ch.operand = '0;
        res_ch.ready   = 1'b0;
        calc_count     = 0;
        stim_count     = 0;
        mismatch_count = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        req_fire       = 1'b0;
        drv_burst_left = 0;
        drv_gap_left   = 0;
        sink_mode      = ALWAYS_READY;
        mode_left      = 0;
        hold_left      = 0;
        next_hold_at   = 150;
        fills          = 0;
        first_seq      = 1'b1;

        // directed: empty-stack errors, wrap on add, most negative over -1,
        // divide by zero, truncation, unused codes, single-entry fold
        queue_request(OP_FINISH, '0, 1'b0);
        queue_request(OP_ADD, '1, 1'b0);
        queue_request(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        queue_request(OP_PUSH, word_t'(1), 1'b0);
        queue_request(OP_ADD, '0, 1'b0);
        queue_request(OP_PUSH, '1, 1'b0);
        queue_request(OP_DIV, '0, 1'b0);
        queue_request(OP_PUSH, '0, 1'b0);
        queue_request(OP_DIV, '0, 1'b0);
        queue_request(OP_PUSH, -word_t'(7), 1'b0);
        queue_request(OP_PUSH, word_t'(2), 1'b0);
        queue_request(OP_PUSH, word_t'(3), 1'b0);
        queue_request(OP_MUL, '0, 1'b0);
        queue_request(OP_PUSH, word_t'(4), 1'b0);
        queue_request(OP_DIV, '0, 1'b0);
        queue_request(OP_PUSH, word_t'(100), 1'b0);
        queue_request(OP_SUB, '0, 1'b0);
        queue_request(OP_FINISH + 3'd1, '1, 1'b0);
        queue_request(OP_FINISH + 3'd2, '1, 1'b0);
        queue_request(OP_SUB, '0, 1'b0);
        queue_request(OP_FINISH, '0, 1'b0);
        queue_request(OP_FINISH + 3'd1, '0, 1'b0);
        queue_request(OP_MUL, '0, 1'b0);
        queue_request(OP_DIV, '0, 1'b0);

        // random: mostly push runs closed by a fold, a few runs that overflow
        // the stack, and some noise of arbitrary codes
        while (stim_count < ITEM_TARGET)
        begin
            kind  = $urandom_range(0, 99);
            drain = first_seq || ($urandom_range(0, 19) == 0);
            first_seq = 1'b0;
            if (fills < 4 && (kind < 3 || (fills == 0 && stim_count > 600)))
            begin
                fills++;
                for (j = 0; j < CALC_DEPTH + 3; j++)
                    queue_request(OP_PUSH, pick_value(), drain && j == 0);
                fold_op = OP_W'($urandom_range(OP_ADD, OP_DIV));
                queue_request(fold_op, $urandom, 1'b0);
                queue_request(OP_FINISH, $urandom, 1'b0);
            end
            else if (kind < 75)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
                for (j = 0; j < n; j++)
                    queue_request(OP_PUSH, pick_value(), drain && j == 0);
                fold_op = OP_W'($urandom_range(OP_ADD, OP_DIV));
                queue_request(fold_op, $urandom, 1'b0);
                if ($urandom_range(0, 1))
                    queue_request(OP_FINISH, $urandom, 1'b0);
            end
            else
            begin
                queue_request(OP_W'($urandom), $urandom, drain);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything offered and taken, then every result back
        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("stack_fold_calculator test passed");
        else
            $display("stack_fold_calculator test failed");
        $finish;
    end

endmodule
